FILE: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared constants and types for the stuffed frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

    // largest raw frame length the hardware accepts, whatever the register says
    localparam int MAX_FRAME = 64;
    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] SYM_ESC    = 8'h1B;
    localparam logic [7:0] SYM_STX    = 8'h80;
    localparam logic [7:0] SYM_ETX    = 8'h81;
    localparam logic [7:0] SYM_STX_AF = 8'hE7;
    localparam logic [7:0] SYM_ETX_AF = 8'hE8;
    localparam logic [7:0] SYM_ESC_AF = 8'h00;

    localparam logic [7:0] SUM_MASK  = 8'h7F;
    localparam logic [6:0] COUNT_TOP = 7'd127;

    localparam logic [6:0] MAX_FRAME_BYTES_RESET = 7'd44;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SUM_BAD   = 3'd1,
        ST_BAD_ESC   = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_TOO_SHORT = 3'd4,
        ST_ABORTED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CLS_STX  = 2'd0,
        CLS_ETX  = 2'd1,
        CLS_ESC  = 2'd2,
        CLS_DATA = 2'd3
    } cls_t;

    // one classified raw byte as it travels from front to back
    typedef struct packed {
        cls_t       cls;
        logic [7:0] raw;
        logic [7:0] esc_dec;
        logic       esc_ok;
    } entry_t;

endpackage

FILE: rtl/stuffed_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_core
// byte-stuffed serial frame deframer with 7-bit xor checksum check
// ----------------------------------------------------------------------------
// Takes one raw serial byte per transfer and sustains one byte per clock
// unless the output stalls. The front classifies each byte on its way into
// the queue, and the back frame engine takes it from there; its result lands
// in the output register. The rate is set by the back engine, which retires
// one queued byte each cycle the output register is free or being drained.
// 0x80 opens a frame, 0x81 closes it, and 0x1B followed by 0xE7, 0xE8 or 0x00
// inside a frame stands for 0x80, 0x81 or 0x1B. Decoded bytes leave one byte
// late (frame id first, with first_of_frame set); the final decoded byte is
// the checksum and is reported on the status transfer at the end byte,
// together with a code: 0 ok, 1 checksum bad, 2 bad escape, 3 too long,
// 4 too short, 5 aborted by a new start byte. Bytes outside a frame produce
// nothing. cfg_wr_data sets the largest raw frame length (start and end
// included), capped at the package limit; write it only while the block is
// idle.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_core #(
    // entries in the queue between classifier and frame engine, 2 to 16
    parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,

    // frame length limit register
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,

    // raw byte input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,

    // decoded bytes and frame status
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_status,
    output logic [7:0] m_out_byte,
    output logic       m_first_of_frame,
    output logic [2:0] m_frame_status
);

    // limit register
    logic [6:0] max_frame_bytes_reg;

    // front to queue
    logic            q_push;
    logic            q_full;
    sfr_pkg::entry_t q_wdata;

    // queue to back
    logic            q_pop;
    logic            q_not_empty;
    sfr_pkg::entry_t q_rdata;

    // config write takes effect on the next clock
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_bytes_reg <= sfr_pkg::MAX_FRAME_BYTES_RESET;
        end else if (cfg_wr_en) begin
            max_frame_bytes_reg <= cfg_wr_data;
        end
    end

    // front: accept the transfer and classify the raw byte
    sfr_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    // decouples input stalls from output stalls
    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    // back: frame state, unstuffing, checksum and result register
    sfr_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .max_frame_bytes  (max_frame_bytes_reg),
        .q_not_empty      (q_not_empty),
        .q_rdata          (q_rdata),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_status      (m_is_status),
        .m_out_byte       (m_out_byte),
        .m_first_of_frame (m_first_of_frame),
        .m_frame_status   (m_frame_status)
    );

endmodule

FILE: rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// accepts raw bytes and classifies them, pre-decoding the escape follower
// ----------------------------------------------------------------------------
module sfr_front (
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_rx_byte,
    input  logic            q_full,
    output logic            q_push,
    output sfr_pkg::entry_t q_wdata
);

    sfr_pkg::entry_t ent;

    always_comb begin
        ent.raw     = s_rx_byte;
        ent.esc_dec = s_rx_byte;
        ent.esc_ok  = 1'b0;
        case (s_rx_byte)
            sfr_pkg::SYM_STX: ent.cls = sfr_pkg::CLS_STX;
            sfr_pkg::SYM_ETX: ent.cls = sfr_pkg::CLS_ETX;
            sfr_pkg::SYM_ESC: ent.cls = sfr_pkg::CLS_ESC;
            default:          ent.cls = sfr_pkg::CLS_DATA;
        endcase
        // value of this byte if it follows an escape
        case (s_rx_byte)
            sfr_pkg::SYM_STX_AF: begin
                ent.esc_dec = sfr_pkg::SYM_STX;
                ent.esc_ok  = 1'b1;
            end
            sfr_pkg::SYM_ETX_AF: begin
                ent.esc_dec = sfr_pkg::SYM_ETX;
                ent.esc_ok  = 1'b1;
            end
            sfr_pkg::SYM_ESC_AF: begin
                ent.esc_dec = sfr_pkg::SYM_ESC;
                ent.esc_ok  = 1'b1;
            end
            default: begin
                ent.esc_dec = s_rx_byte;
                ent.esc_ok  = 1'b0;
            end
        endcase
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign q_wdata = ent;

endmodule

FILE: rtl/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue
// short register queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module sfr_queue #(
    parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sfr_pkg::entry_t wdata,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output sfr_pkg::entry_t rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sfr_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign rdata     = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    // a pop must find an entry and the fill level never passes the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue popped while empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue fill level beyond depth");

endmodule

FILE: rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// frame state machine: unstuffing, checksum, status and the output register
// ----------------------------------------------------------------------------
module sfr_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [6:0]      max_frame_bytes,
    input  logic            q_not_empty,
    input  sfr_pkg::entry_t q_rdata,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_is_status,
    output logic [7:0]      m_out_byte,
    output logic            m_first_of_frame,
    output logic [2:0]      m_frame_status
);

    logic       in_frame_reg, in_frame_next;
    logic       escape_seen_reg, escape_seen_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_is_first_reg, held_is_first_next;
    logic [7:0] xor_sum_reg, xor_sum_next;
    logic [6:0] raw_count_reg, raw_count_next;
    logic [2:0] error_code_reg, error_code_next;

    logic       m_valid_reg, m_valid_next;
    logic       m_is_status_reg, m_is_status_next;
    logic [7:0] m_out_byte_reg, m_out_byte_next;
    logic       m_first_reg, m_first_next;
    logic [2:0] m_status_reg, m_status_next;

    logic [6:0] limit;
    logic [6:0] raw_inc;
    logic [7:0] total;
    logic [7:0] held_or_zero;
    logic       have_dec;
    logic [7:0] dec;
    logic       emit;

    assign limit = ({2'b00, max_frame_bytes} < 9'(sfr_pkg::MAX_FRAME)) ?
                   max_frame_bytes : 7'(sfr_pkg::MAX_FRAME);
    assign raw_inc      = (raw_count_reg == sfr_pkg::COUNT_TOP) ?
                          raw_count_reg : raw_count_reg + 7'd1;
    assign total        = {1'b0, raw_count_reg} + 8'd1;
    assign held_or_zero = held_valid_reg ? held_byte_reg : 8'h00;

    // one entry per cycle whenever the output register is free or draining
    assign q_pop = q_not_empty && (!m_valid_reg || m_ready);

    always_comb begin
        in_frame_next      = in_frame_reg;
        escape_seen_next   = escape_seen_reg;
        held_valid_next    = held_valid_reg;
        held_byte_next     = held_byte_reg;
        held_is_first_next = held_is_first_reg;
        xor_sum_next       = xor_sum_reg;
        raw_count_next     = raw_count_reg;
        error_code_next    = error_code_reg;

        emit             = 1'b0;
        m_is_status_next = m_is_status_reg;
        m_out_byte_next  = m_out_byte_reg;
        m_first_next     = m_first_reg;
        m_status_next    = m_status_reg;
        have_dec         = 1'b0;
        dec              = q_rdata.raw;

        if (q_pop) begin
            case (q_rdata.cls)
                sfr_pkg::CLS_STX: begin
                    if (in_frame_reg) begin
                        emit             = 1'b1;
                        m_is_status_next = 1'b1;
                        m_out_byte_next  = held_or_zero;
                        m_first_next     = 1'b0;
                        m_status_next    = sfr_pkg::ST_ABORTED;
                    end
                    in_frame_next      = 1'b1;
                    escape_seen_next   = 1'b0;
                    held_valid_next    = 1'b0;
                    held_byte_next     = 8'h00;
                    held_is_first_next = 1'b0;
                    xor_sum_next       = 8'h00;
                    raw_count_next     = 7'd1;
                    error_code_next    = sfr_pkg::ST_OK;
                end
                sfr_pkg::CLS_ETX: begin
                    if (in_frame_reg) begin
                        emit             = 1'b1;
                        m_is_status_next = 1'b1;
                        m_out_byte_next  = held_or_zero;
                        m_first_next     = 1'b0;
                        if (error_code_reg != sfr_pkg::ST_OK) begin
                            m_status_next = error_code_reg;
                        end else if (total > {1'b0, limit}) begin
                            m_status_next = sfr_pkg::ST_TOO_LONG;
                        end else if (escape_seen_reg) begin
                            m_status_next = sfr_pkg::ST_BAD_ESC;
                        end else if (!held_valid_reg || held_is_first_reg) begin
                            m_status_next = sfr_pkg::ST_TOO_SHORT;
                        end else if ((xor_sum_reg & sfr_pkg::SUM_MASK) == held_byte_reg) begin
                            m_status_next = sfr_pkg::ST_OK;
                        end else begin
                            m_status_next = sfr_pkg::ST_SUM_BAD;
                        end
                        in_frame_next      = 1'b0;
                        escape_seen_next   = 1'b0;
                        held_valid_next    = 1'b0;
                        held_is_first_next = 1'b0;
                    end
                end
                default: begin
                    if (in_frame_reg) begin
                        raw_count_next = raw_inc;
                        if (error_code_reg != sfr_pkg::ST_OK) begin
                            // rest of a failed frame is swallowed
                        end else if (raw_inc >= limit) begin
                            error_code_next = sfr_pkg::ST_TOO_LONG;
                        end else if (escape_seen_reg) begin
                            escape_seen_next = 1'b0;
                            if (q_rdata.esc_ok) begin
                                have_dec = 1'b1;
                                dec      = q_rdata.esc_dec;
                            end else begin
                                error_code_next = sfr_pkg::ST_BAD_ESC;
                            end
                        end else if (q_rdata.cls == sfr_pkg::CLS_ESC) begin
                            escape_seen_next = 1'b1;
                        end else begin
                            have_dec = 1'b1;
                            dec      = q_rdata.raw;
                        end
                    end
                end
            endcase

            // decoded bytes leave one step late, the last one is the checksum
            if (have_dec) begin
                if (held_valid_reg) begin
                    emit               = 1'b1;
                    m_is_status_next   = 1'b0;
                    m_out_byte_next    = held_byte_reg;
                    m_first_next       = held_is_first_reg;
                    m_status_next      = sfr_pkg::ST_OK;
                    xor_sum_next       = xor_sum_reg ^ held_byte_reg;
                    held_is_first_next = 1'b0;
                end else begin
                    held_valid_next    = 1'b1;
                    held_is_first_next = 1'b1;
                end
                held_byte_next = dec;
            end
        end

        if (q_pop) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg      <= 1'b0;
            escape_seen_reg   <= 1'b0;
            held_valid_reg    <= 1'b0;
            held_byte_reg     <= 8'h00;
            held_is_first_reg <= 1'b0;
            xor_sum_reg       <= 8'h00;
            raw_count_reg     <= 7'd0;
            error_code_reg    <= sfr_pkg::ST_OK;
            m_valid_reg       <= 1'b0;
        end else begin
            in_frame_reg      <= in_frame_next;
            escape_seen_reg   <= escape_seen_next;
            held_valid_reg    <= held_valid_next;
            held_byte_reg     <= held_byte_next;
            held_is_first_reg <= held_is_first_next;
            xor_sum_reg       <= xor_sum_next;
            raw_count_reg     <= raw_count_next;
            error_code_reg    <= error_code_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_is_status_reg <= m_is_status_next;
        m_out_byte_reg  <= m_out_byte_next;
        m_first_reg     <= m_first_next;
        m_status_reg    <= m_status_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_is_status      = m_is_status_reg;
    assign m_out_byte       = m_out_byte_reg;
    assign m_first_of_frame = m_first_reg;
    assign m_frame_status   = m_status_reg;

    // status transfers never mark a frame id, data transfers carry no status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_is_status_reg |-> !m_first_reg)
        else $error("status result flagged as frame id");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_is_status_reg |-> (m_status_reg == sfr_pkg::ST_OK))
        else $error("data result with nonzero status");
    // a held frame id implies a held byte, and escapes only live inside a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_is_first_reg |-> held_valid_reg)
        else $error("frame id flag without held byte");
    assert property (@(posedge aclk) disable iff (!aresetn)
        escape_seen_reg |-> in_frame_reg)
        else $error("escape pending outside a frame");

endmodule
